@@ hw/rtl/sacts_pkg.sv @@
// Shared types and constants for the set-associative cache tag store.
package sacts_pkg;

  localparam int MAX_SETS_DEF      = 256;
  localparam int MAX_WAYS_DEF      = 8;
  localparam int ADDRESS_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH       = 2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 104;

  // configuration register indexes
  localparam logic [1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] CFG_INDEX_BITS  = 2'd1;
  localparam logic [1:0] CFG_WAYS_IN_USE = 2'd2;

  localparam logic [4:0] OFFSET_BITS_RST = 5'd2;
  localparam logic [3:0] INDEX_BITS_RST  = 4'd0;
  localparam logic [3:0] WAYS_IN_USE_RST = 4'd1;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_FILL   = 2'd1,
    CMD_INVAL  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_PICK  = 2'd1,
    BK_WRITE = 2'd2
  } bk_state_t;

  // effective configuration, already clamped
  typedef struct packed {
    logic [4:0] offset_bits;
    logic [3:0] eff_index_bits;
    logic [4:0] eff_ways;
  } cfg_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] victim_block_address;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } res_t;

endpackage

@@ hw/rtl/set_assoc_cache_tag_store.sv @@
// Each item is a read-modify-write of a set row (pop and read, victim pick, write back);
// the back end pops no new item until the last is written back, and the write back, which
// also registers the result, waits while the output register holds an unaccepted result.
// A 2-entry queue lets the input take beats while the back end works or stalls.
// Reset (rst_n low, synchronous) clears control, counters and the per-set row
// flags; rows read as empty until first written, so no clearing pass is run.
module set_assoc_cache_tag_store #(
  parameter int MAX_SETS      = sacts_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS      = sacts_pkg::MAX_WAYS_DEF,
  parameter int ADDRESS_WIDTH = sacts_pkg::ADDRESS_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // command[1:0], address[33:2], zero pad
  input  logic [sacts_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // hit[0], victim_block_address[32:1], hit_total[64:33], miss_total[96:65], zero pad
  output logic [sacts_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [4:0]                         cfg_wdata
);

  localparam int SW     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int IW     = 2 + SW + ADDRESS_WIDTH;
  localparam int MAX_IB = $clog2(MAX_SETS + 1) - 1;

  logic [4:0] offset_bits_r;
  logic [3:0] index_bits_r;
  logic [3:0] ways_in_use_r;

  sacts_pkg::cfg_t cfg;
  sacts_pkg::res_t res;

  logic          q_full, q_push, q_pop, q_valid;
  logic [IW-1:0] q_in, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= sacts_pkg::OFFSET_BITS_RST;
      index_bits_r  <= sacts_pkg::INDEX_BITS_RST;
      ways_in_use_r <= sacts_pkg::WAYS_IN_USE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sacts_pkg::CFG_OFFSET_BITS: offset_bits_r <= cfg_wdata;
        sacts_pkg::CFG_INDEX_BITS:  index_bits_r  <= cfg_wdata[3:0];
        sacts_pkg::CFG_WAYS_IN_USE: ways_in_use_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // clamp index bits to the set count and ways to the built associativity (zero ways reads as one)
  always_comb begin
    cfg.offset_bits    = offset_bits_r;
    cfg.eff_index_bits = (index_bits_r > 4'(MAX_IB)) ? 4'(MAX_IB) : index_bits_r;
    if (ways_in_use_r == '0) begin
      cfg.eff_ways = 5'd1;
    end else if (5'(ways_in_use_r) > 5'(MAX_WAYS)) begin
      cfg.eff_ways = 5'(MAX_WAYS);
    end else begin
      cfg.eff_ways = 5'(ways_in_use_r);
    end
  end

  sacts_front #(
    .MAX_SETS      (MAX_SETS),
    .ADDRESS_WIDTH (ADDRESS_WIDTH),
    .SW            (SW),
    .IW            (IW)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg       (cfg),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  sacts_queue #(
    .WIDTH (IW),
    .DEPTH (sacts_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .not_empty (q_valid)
  );

  sacts_back #(
    .MAX_SETS      (MAX_SETS),
    .MAX_WAYS      (MAX_WAYS),
    .ADDRESS_WIDTH (ADDRESS_WIDTH),
    .SW            (SW),
    .IW            (IW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {7'd0, res.miss_total, res.hit_total, res.victim_block_address, res.hit};

`ifndef NO_ASSERTIONS
  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.hit |-> res.hit_total != 32'd0)
    else $error("hit reported with zero hit total");

  a_hit_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> res.hit_total >= $past(res.hit_total))
    else $error("hit total decreased");

  a_one_total_moves: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !(res.hit_total != $past(res.hit_total) &&
                       res.miss_total != $past(res.miss_total)))
    else $error("hit and miss totals moved together");
`endif

endmodule

@@ hw/rtl/sacts_queue.sv @@
// Small FIFO between the front classifier and the back executor.
module sacts_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sacts_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/sacts_front.sv @@
// Front end: accepts input beats and splits the address into set and tag.
module sacts_front #(
  parameter int MAX_SETS      = sacts_pkg::MAX_SETS_DEF,
  parameter int ADDRESS_WIDTH = sacts_pkg::ADDRESS_WIDTH_DEF,
  parameter int SW            = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
  parameter int IW            = 2 + SW + ADDRESS_WIDTH
) (
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sacts_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  sacts_pkg::cfg_t                   cfg,
  input  logic                              q_full,
  output logic                              q_push,
  output logic [IW-1:0]                     q_item
);

  localparam int AW = ADDRESS_WIDTH;

  logic [1:0]    cmd;
  logic [AW-1:0] addr;
  logic [AW-1:0] set_mask;
  logic [AW-1:0] set_full;
  logic [AW-1:0] tag;
  logic [5:0]    tag_shift;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    cmd       = in_tdata[1:0];
    addr      = in_tdata[AW+1:2];
    set_mask  = ~({AW{1'b1}} << cfg.eff_index_bits);
    // shifts past the address width give zero, covering the wide splits
    set_full  = (addr >> cfg.offset_bits) & set_mask;
    tag_shift = 6'(cfg.offset_bits) + 6'(cfg.eff_index_bits);
    tag       = addr >> tag_shift;
    q_item    = {cmd, set_full[SW-1:0], tag};
  end

endmodule

@@ hw/rtl/sacts_back.sv @@
// Back end: read-modify-write of one set row, victim pick, counters, result register.
module sacts_back #(
  parameter int MAX_SETS      = sacts_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS      = sacts_pkg::MAX_WAYS_DEF,
  parameter int ADDRESS_WIDTH = sacts_pkg::ADDRESS_WIDTH_DEF,
  parameter int SW            = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
  parameter int IW            = 2 + SW + ADDRESS_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sacts_pkg::cfg_t   cfg,
  input  logic              q_valid,
  input  logic [IW-1:0]     q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output sacts_pkg::res_t   res
);

  localparam int AW = ADDRESS_WIDTH;
  localparam int WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int W2 = 1 << WW;
  localparam int KW = 34;
  localparam int NN = 2 * W2 - 1;

  // set rows
  logic [MAX_WAYS-1:0][AW-1:0] tag_mem_r   [MAX_SETS];
  logic [MAX_WAYS-1:0][31:0]   stamp_mem_r [MAX_SETS];
  logic [MAX_WAYS-1:0]         wr_mem_r    [MAX_SETS];
  logic [MAX_WAYS-1:0]         vl_mem_r    [MAX_SETS];
  logic [31:0]                 ctr_mem_r   [MAX_SETS];
  logic [MAX_SETS-1:0]         row_init_r;

  sacts_pkg::bk_state_t state_r, state_nxt;
  sacts_pkg::cmd_t      cmd_r;
  logic [SW-1:0]        set_r;
  logic [AW-1:0]        tag_r;

  logic [MAX_WAYS-1:0][AW-1:0] rd_tags_r;
  logic [MAX_WAYS-1:0][31:0]   rd_stamps_r;
  logic [MAX_WAYS-1:0]         rd_written_r, rd_valid_r;
  logic [31:0]                 rd_ctr_r;
  logic                        rd_init_r;

  logic [WW-1:0] victim_r, inv_idx_r;
  logic          hit_r, inv_hit_r;

  logic [31:0]     hit_cnt_r, miss_cnt_r, hit_cnt_nxt, miss_cnt_nxt;
  logic            out_valid_r;
  sacts_pkg::res_t res_r, res_nxt;

  logic rd_en, wb_en, ld, pick_en;

  logic [MAX_WAYS-1:0] written_e, valid_e, in_use;
  logic [31:0]         ctr_e;

  logic [KW-1:0] key [NN];
  logic [WW-1:0] kidx [NN];
  logic [WW-1:0] victim_c, inv_idx_c;
  logic          hit_c, inv_hit_c;

  logic [MAX_WAYS-1:0][AW-1:0] new_tags;
  logic [MAX_WAYS-1:0][31:0]   new_stamps;
  logic [MAX_WAYS-1:0]         new_wr, new_vl;
  logic [31:0]                 new_ctr;
  logic [AW-1:0]               vtag;

  logic [SW-1:0] q_set;

  assign q_set     = q_item[AW+SW-1:AW];
  assign ld        = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign res       = res_r;

  // state machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sacts_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    pick_en   = 1'b0;
    wb_en     = 1'b0;
    unique case (state_r)
      sacts_pkg::BK_IDLE: begin
        if (q_valid) begin
          rd_en     = 1'b1;
          state_nxt = sacts_pkg::BK_PICK;
        end
      end
      sacts_pkg::BK_PICK: begin
        pick_en   = 1'b1;
        state_nxt = sacts_pkg::BK_WRITE;
      end
      sacts_pkg::BK_WRITE: begin
        if (ld) begin
          wb_en     = 1'b1;
          state_nxt = sacts_pkg::BK_IDLE;
        end
      end
      default: state_nxt = sacts_pkg::BK_IDLE;
    endcase
  end

  assign q_pop = rd_en;

  // row memories: one registered read, one write per item
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_tags_r    <= tag_mem_r[q_set];
      rd_stamps_r  <= stamp_mem_r[q_set];
      rd_written_r <= wr_mem_r[q_set];
      rd_valid_r   <= vl_mem_r[q_set];
      rd_ctr_r     <= ctr_mem_r[q_set];
      cmd_r        <= sacts_pkg::cmd_t'(q_item[IW-1:IW-2]);
      set_r        <= q_set;
      tag_r        <= q_item[AW-1:0];
    end
    if (wb_en) begin
      tag_mem_r[set_r]   <= new_tags;
      stamp_mem_r[set_r] <= new_stamps;
      wr_mem_r[set_r]    <= new_wr;
      vl_mem_r[set_r]    <= new_vl;
      ctr_mem_r[set_r]   <= new_ctr;
    end
  end

  // a row never written reads as all clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_init_r <= '0;
      rd_init_r  <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_init_r <= row_init_r[q_set];
      end
      if (wb_en) begin
        row_init_r[set_r] <= 1'b1;
      end
    end
  end

  always_comb begin
    written_e = rd_init_r ? rd_written_r : '0;
    valid_e   = rd_init_r ? rd_valid_r : '0;
    ctr_e     = rd_init_r ? rd_ctr_r : '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i] = (5'(i) < cfg.eff_ways);
    end
  end

  // victim: first invalid way, else first way with the smallest stamp
  always_comb begin
    for (int i = 0; i < W2; i++) begin
      key[W2-1+i]  = '1;
      kidx[W2-1+i] = WW'(i);
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (in_use[i]) begin
        key[W2-1+i] = {1'b0, valid_e[i], valid_e[i] ? rd_stamps_r[i] : 32'd0};
      end
    end
    for (int n = W2 - 2; n >= 0; n--) begin
      if (key[2*n+2] < key[2*n+1]) begin
        key[n]  = key[2*n+2];
        kidx[n] = kidx[2*n+2];
      end else begin
        key[n]  = key[2*n+1];
        kidx[n] = kidx[2*n+1];
      end
    end
    victim_c = kidx[0];
  end

  always_comb begin
    hit_c     = 1'b0;
    inv_hit_c = 1'b0;
    inv_idx_c = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (in_use[i] && rd_tags_r[i] == tag_r) begin
        if (valid_e[i]) begin
          hit_c = 1'b1;
        end
        if (written_e[i]) begin
          inv_hit_c = 1'b1;
          inv_idx_c = WW'(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pick_en) begin
      victim_r  <= victim_c;
      hit_r     <= hit_c;
      inv_hit_r <= inv_hit_c;
      inv_idx_r <= inv_idx_c;
    end
  end

  // row update and result
  always_comb begin
    new_tags   = rd_tags_r;
    new_stamps = rd_stamps_r;
    new_wr     = written_e;
    new_vl     = valid_e;
    new_ctr    = ctr_e;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    case (cmd_r)
      sacts_pkg::CMD_LOOKUP: begin
        if (hit_r) begin
          hit_cnt_nxt = (hit_cnt_r == '1) ? hit_cnt_r : hit_cnt_r + 1'b1;
        end else begin
          miss_cnt_nxt = (miss_cnt_r == '1) ? miss_cnt_r : miss_cnt_r + 1'b1;
        end
      end
      sacts_pkg::CMD_FILL: begin
        new_tags[victim_r]   = tag_r;
        new_stamps[victim_r] = ctr_e;
        new_wr[victim_r]     = 1'b1;
        new_vl[victim_r]     = 1'b1;
        new_ctr              = ctr_e + 1'b1;
      end
      sacts_pkg::CMD_INVAL: begin
        if (inv_hit_r) begin
          new_vl[inv_idx_r] = 1'b0;
        end
      end
      default: ;
    endcase
    vtag = written_e[victim_r] ? rd_tags_r[victim_r] : '0;
    res_nxt.hit                  = (cmd_r == sacts_pkg::CMD_LOOKUP) && hit_r;
    res_nxt.victim_block_address = (32'(vtag) << cfg.eff_index_bits) | 32'(set_r);
    res_nxt.hit_total            = hit_cnt_nxt;
    res_nxt.miss_total           = miss_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      res_r       <= '0;
    end else begin
      if (wb_en) begin
        hit_cnt_r   <= hit_cnt_nxt;
        miss_cnt_r  <= miss_cnt_nxt;
        res_r       <= res_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the set-associative cache tag store.
`timescale 1ns / 1ps

module testbench;
  import sacts_pkg::*;

  localparam int SETS    = MAX_SETS_DEF;
  localparam int WAYS    = MAX_WAYS_DEF;
  localparam int ENTRIES = SETS * WAYS;
  localparam int SET_LOG = $clog2(SETS);

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata   = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    cfg_we     = 1'b0;
  logic [1:0]              cfg_index  = CFG_OFFSET_BITS;
  logic [4:0]              cfg_wdata  = '0;

  set_assoc_cache_tag_store i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the tag store
  logic [31:0] shadow_tag     [ENTRIES];
  bit          shadow_written [ENTRIES];
  bit          shadow_valid   [ENTRIES];
  logic [31:0] shadow_stamp   [ENTRIES];
  logic [31:0] shadow_fill_cnt [SETS];
  logic [31:0] shadow_hits;
  logic [31:0] shadow_misses;
  logic [4:0]  shadow_offset;
  logic [3:0]  shadow_index;
  logic [3:0]  shadow_ways;

  res_t pending_tag_results [$];
  int   error_count     = 0;
  int   accesses_sent   = 0;
  int   results_checked = 0;
  int   settings_used   = 1;
  int   send_idle_pct   = 0;
  int   recv_idle_pct   = 0;
  int   hold_left       = 0;

  function automatic int unsigned set_bits_in_use();
    return (shadow_index > SET_LOG) ? SET_LOG : shadow_index;
  endfunction

  task automatic predict_tag_store(input cmd_t c, input logic [31:0] a, output res_t r);
    int unsigned ib, nways, set_i, base, v, i;
    logic [31:0] tg, vtag;
    logic [63:0] vaddr;
    bit found;
    ib = set_bits_in_use();
    nways = (shadow_ways == 0) ? 1 : ((shadow_ways > WAYS) ? WAYS : shadow_ways);
    set_i = 0;
    tg = '0;
    if (shadow_offset < 32) set_i = (a >> shadow_offset) & ((1 << ib) - 1);
    if (shadow_offset + ib < 32) tg = a >> (shadow_offset + ib);
    base = set_i * WAYS;
    // first free way wins, else the oldest fill
    v = 0;
    for (i = 0; i < nways; i++) begin
      if (!shadow_valid[base + i]) begin
        v = i;
        break;
      end
      if (shadow_stamp[base + i] < shadow_stamp[base + v]) v = i;
    end
    vtag = shadow_written[base + v] ? shadow_tag[base + v] : 32'd0;
    vaddr = ({32'd0, vtag} << ib) | 64'(set_i);
    found = 1'b0;
    case (c)
      CMD_LOOKUP: begin
        for (i = 0; i < nways; i++) begin
          if (shadow_valid[base + i] && shadow_tag[base + i] == tg) begin
            found = 1'b1;
            break;
          end
        end
        if (found) begin
          if (shadow_hits != 32'hFFFF_FFFF) shadow_hits++;
        end else if (shadow_misses != 32'hFFFF_FFFF) begin
          shadow_misses++;
        end
      end
      CMD_FILL: begin
        shadow_tag[base + v]     = tg;
        shadow_written[base + v] = 1'b1;
        shadow_valid[base + v]   = 1'b1;
        shadow_stamp[base + v]   = shadow_fill_cnt[set_i];
        shadow_fill_cnt[set_i]   = shadow_fill_cnt[set_i] + 32'd1;
      end
      CMD_INVAL: begin
        // a stale (invalid but written) way still matches
        for (i = 0; i < nways; i++) begin
          if (shadow_written[base + i] && shadow_tag[base + i] == tg) begin
            shadow_valid[base + i] = 1'b0;
            break;
          end
        end
      end
      default: ;
    endcase
    r.hit                  = found;
    r.victim_block_address = vaddr[31:0];
    r.hit_total            = shadow_hits;
    r.miss_total           = shadow_misses;
  endtask

  task automatic send_access(input cmd_t c, input logic [31:0] a, input bit typed,
                             input res_t want);
    res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, a, c};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_tag_store(c, a, r);
    pending_tag_results.push_back(typed ? want : r);
    accesses_sent++;
  endtask

  // drop valid, wait for every pending result, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_tag_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input logic [4:0] off, input logic [3:0] idx,
                              input logic [3:0] ways);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OFFSET_BITS;
    cfg_wdata <= off;
    @(posedge clk);
    cfg_index <= CFG_INDEX_BITS;
    cfg_wdata <= {1'b0, idx};
    @(posedge clk);
    cfg_index <= CFG_WAYS_IN_USE;
    cfg_wdata <= {1'b0, ways};
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_offset = off;
    shadow_index  = idx;
    shadow_ways   = ways;
    settings_used++;
  endtask

  // result beat checker and receiver back-pressure
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.hit                  = out_tdata[0];
      got.victim_block_address = out_tdata[32:1];
      got.hit_total            = out_tdata[64:33];
      got.miss_total           = out_tdata[96:65];
      if (pending_tag_results.size() == 0) begin
        $display("%0t: result beat with nothing pending: %h", $time, out_tdata);
        error_count++;
      end else begin
        want = pending_tag_results.pop_front();
        results_checked++;
        if (got.hit !== want.hit) begin
          $display("%0t: hit expected %0d got %0d", $time, want.hit, got.hit);
          error_count++;
        end
        if (got.victim_block_address !== want.victim_block_address) begin
          $display("%0t: victim_block_address expected %h got %h", $time,
                   want.victim_block_address, got.victim_block_address);
          error_count++;
        end
        if (got.hit_total !== want.hit_total) begin
          $display("%0t: hit_total expected %0d got %0d", $time,
                   want.hit_total, got.hit_total);
          error_count++;
        end
        if (got.miss_total !== want.miss_total) begin
          $display("%0t: miss_total expected %0d got %0d", $time,
                   want.miss_total, got.miss_total);
          error_count++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  typedef struct {
    bit          reconf;
    logic [4:0]  off;
    logic [3:0]  idx;
    logic [3:0]  ways;
    cmd_t        cmd;
    logic [31:0] addr;
    bit          typed;
    bit          w_hit;
    logic [31:0] w_vba;
    logic [31:0] w_hits;
    logic [31:0] w_misses;
  } access_row_t;

  // rows up to the first reconfiguration run with the reset settings:
  // offset 2, no index bits, one way
  access_row_t access_rows [22] = '{
    '{0, 0,  0,  0, CMD_LOOKUP, 32'h0000_0000, 1, 0, 32'h0000_0000, 0, 1},
    '{0, 0,  0,  0, CMD_FILL,   32'hFFFF_FFFF, 1, 0, 32'h0000_0000, 0, 1},
    '{0, 0,  0,  0, CMD_LOOKUP, 32'hFFFF_FFFC, 1, 1, 32'h3FFF_FFFF, 1, 1},
    '{0, 0,  0,  0, CMD_NOP,    32'h1234_5678, 1, 0, 32'h3FFF_FFFF, 1, 1},
    '{0, 0,  0,  0, CMD_INVAL,  32'hFFFF_FFFF, 1, 0, 32'h3FFF_FFFF, 1, 1},
    '{0, 0,  0,  0, CMD_LOOKUP, 32'hFFFF_FFFF, 1, 0, 32'h3FFF_FFFF, 1, 2},
    '{0, 0,  0,  0, CMD_INVAL,  32'h0000_0000, 1, 0, 32'h3FFF_FFFF, 1, 2},
    '{0, 0,  0,  0, CMD_FILL,   32'h0000_0000, 1, 0, 32'h3FFF_FFFF, 1, 2},
    '{0, 0,  0,  0, CMD_LOOKUP, 32'h0000_0003, 1, 1, 32'h0000_0000, 2, 2},
    '{1, 0,  8,  8, CMD_FILL,   32'h0000_00FF, 0, 0, 0, 0, 0},
    '{0, 0,  0,  0, CMD_LOOKUP, 32'h0000_01FF, 0, 0, 0, 0, 0},
    '{0, 0,  0,  0, CMD_FILL,   32'h0000_01FF, 0, 0, 0, 0, 0},
    '{0, 0,  0,  0, CMD_LOOKUP, 32'h0000_01FF, 0, 0, 0, 0, 0},
    '{1, 4,  15, 0, CMD_FILL,   32'h5A5A_5A5A, 0, 0, 0, 0, 0},
    '{0, 0,  0,  0, CMD_FILL,   32'hA5A5_5A5A, 0, 0, 0, 0, 0},
    '{0, 0,  0,  0, CMD_LOOKUP, 32'h5A5A_5A5A, 0, 0, 0, 0, 0},
    '{1, 31, 15, 15, CMD_FILL,  32'h8000_0000, 0, 0, 0, 0, 0},
    '{0, 0,  0,  0, CMD_LOOKUP, 32'h8765_4321, 0, 0, 0, 0, 0},
    '{0, 0,  0,  0, CMD_INVAL,  32'hFFFF_FFFF, 0, 0, 0, 0, 0},
    '{1, 16, 8,  15, CMD_LOOKUP, 32'hFFFF_0000, 0, 0, 0, 0, 0},
    '{1, 0,  0,  15, CMD_FILL,  32'hFFFF_FFFF, 0, 0, 0, 0, 0},
    '{0, 0,  0,  0, CMD_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 0, 0}
  };

  int phase_off  [7] = '{0, 16, 31, 4, 12, 6, 2};
  int phase_idx  [7] = '{8, 3, 15, 2, 5, 1, 0};
  int phase_ways [7] = '{8, 4, 15, 0, 3, 2, 1};

  initial begin
    res_t        want;
    logic [31:0] tag_pool [6];
    int unsigned set_pool [2];
    logic [63:0] full;
    logic [31:0] a;
    cmd_t        c;
    int          pick, ph, k, n, mode;
    for (n = 0; n < ENTRIES; n++) begin
      shadow_tag[n]     = '0;
      shadow_written[n] = 1'b0;
      shadow_valid[n]   = 1'b0;
      shadow_stamp[n]   = '0;
    end
    for (n = 0; n < SETS; n++) shadow_fill_cnt[n] = '0;
    shadow_hits   = '0;
    shadow_misses = '0;
    shadow_offset = OFFSET_BITS_RST;
    shadow_index  = INDEX_BITS_RST;
    shadow_ways   = WAYS_IN_USE_RST;

    send_idle_pct = 6;
    recv_idle_pct = 78;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (access_rows[n]) begin
      if (access_rows[n].reconf) begin
        drain();
        apply_config(access_rows[n].off, access_rows[n].idx, access_rows[n].ways);
      end
      want.hit                  = access_rows[n].w_hit;
      want.victim_block_address = access_rows[n].w_vba;
      want.hit_total            = access_rows[n].w_hits;
      want.miss_total           = access_rows[n].w_misses;
      send_access(access_rows[n].cmd, access_rows[n].addr, access_rows[n].typed, want);
    end

    want = '0;
    for (ph = 0; ph < 7; ph++) begin
      drain();
      apply_config(5'(phase_off[ph]), 4'(phase_idx[ph]), 4'(phase_ways[ph]));
      mode = ph * 3 / 7;
      send_idle_pct = (mode == 0) ? 6 : ((mode == 1) ? 78 : 0);
      recv_idle_pct = (mode == 0) ? 78 : ((mode == 1) ? 6 : 0);
      // a few tags over two sets so that ways fill up and get replaced
      for (n = 0; n < 6; n++) tag_pool[n] = $urandom;
      for (n = 0; n < 2; n++) set_pool[n] = $urandom & ((1 << set_bits_in_use()) - 1);
      for (k = 0; k < 112; k++) begin
        if (ph == 4 && k == 50) begin
          // long receiver hold-off while the sender keeps offering beats
          drain();
          hold_left = 60;
        end
        if (ph == 4 && k == 70) drain();
        pick = $urandom_range(99);
        if (pick < 40) c = CMD_LOOKUP;
        else if (pick < 70) c = CMD_FILL;
        else if (pick < 92) c = CMD_INVAL;
        else c = CMD_NOP;
        if ($urandom_range(9) == 0) begin
          a = $urandom;
        end else begin
          full = ({32'd0, tag_pool[$urandom_range(5)]} << (shadow_offset + set_bits_in_use()))
               | (64'(set_pool[$urandom_range(1)]) << shadow_offset)
               | (64'($urandom) & ((64'd1 << shadow_offset) - 64'd1));
          a = full[31:0];
        end
        send_access(c, a, 1'b0, want);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Covered %0d accesses over %0d cache settings, %0d results checked.",
             accesses_sent, settings_used, results_checked);
    $display("Lookups seen: %0d hits, %0d misses.", shadow_hits, shadow_misses);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results pending", pending_tag_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
